@@ src/swip_pkg.sv @@
// shared types, constants and helpers of the shock wave incident pressure core
package swip_pkg;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_PRESSURE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_TIME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOWNESS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Z      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_OFFSET  = 3'd7;

  // wave modes
  localparam logic [1:0] MODE_PLANE_EXP  = 2'd0;
  localparam logic [1:0] MODE_PLANE_STEP = 2'd1;
  localparam logic [1:0] MODE_SPHERE     = 2'd2;
  localparam logic [1:0] MODE_UNUSED     = 2'd3;

  // reset values of the registers
  localparam logic [1:0]  RST_WAVE_MODE    = MODE_SPHERE;
  localparam logic [30:0] RST_PEAK         = 31'd0;
  localparam logic [31:0] RST_DECAY_TIME   = 32'd1000000;
  localparam logic [23:0] RST_SLOWNESS     = 24'd666667;
  localparam logic [31:0] RST_FRONT_OFFSET = 32'd65536;

  // fixed-point constants
  localparam logic [30:0] LOG2E_Q30    = 31'd1549082005;
  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [30:0] ONE_Q30      = 31'h40000000;
  localparam logic [30:0] MAX_PRESSURE = 31'h7FFFFFFF;
  localparam logic signed [63:0] TOL_Q16 = -64'sd65536000;

  // reciprocal multipliers for the series divisors
  localparam logic [63:0] DIV3_MUL = 64'd1431655766;
  localparam logic [63:0] DIV5_MUL = 64'd858993460;
  localparam logic [63:0] DIV6_MUL = 64'd715827883;
  localparam logic [63:0] DIV7_MUL = 64'd1227133514;

  // per-item sideband carried down the pipeline
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        t;
    logic               shadow;
    logic               last;
    logic [33:0]        r;
    logic               arrived;
    logic               neg;
    logic signed [16:0] k;
    logic signed [17:0] rs;
  } side_t;

  // floor(x / d) for d in 1..8, x below 2^30
  function automatic logic [29:0] div_small(input logic [29:0] x, input logic [3:0] d);
    logic [63:0] p;
    logic [29:0] q;
    p = '0;
    q = x;
    unique case (d)
      4'd1: q = x;
      4'd2: q = x >> 1;
      4'd3: begin
        p = {34'd0, x} * DIV3_MUL;
        q = p[61:32];
      end
      4'd4: q = x >> 2;
      4'd5: begin
        p = {34'd0, x} * DIV5_MUL;
        q = p[61:32];
      end
      4'd6: begin
        p = {34'd0, x} * DIV6_MUL;
        q = p[61:32];
      end
      4'd7: begin
        p = {34'd0, x} * DIV7_MUL;
        q = p[62:33];
      end
      4'd8: q = x >> 3;
      default: q = x;
    endcase
    return q;
  endfunction

endpackage

@@ src/shock_wave_incident_pressure_core.sv @@
// shock wave incident pressure core: radius, delay, decay and gain pipeline
// from input accept to result valid, every step is one register stage
// throughput: one item per cycle unless stalled; the bit-per-stage square root and
// the two restoring dividers (tau, radius) set the depth, each stage holds one step
// a stalled output only holds the stages behind it that are full; bubbles still fill
// reset: synchronous rst clears all valid bits and loads the register reset values
module shock_wave_incident_pressure_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // node_x, node_y, node_z, time_ns
  input  logic         s_tuser,   // in_shadow
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // pressure, zero pad
  output logic         m_tuser,   // arrived
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [swip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int RT_N    = 34;
  localparam int QD_N    = 31;
  localparam int TM_N    = 8;
  localparam int RD_N    = 31;
  localparam int ST_IN   = 0;
  localparam int ST_SQ   = ST_IN + 1;
  localparam int ST_SUM  = ST_SQ + 1;
  localparam int ST_RT0  = ST_SUM + 1;
  localparam int ST_DIFF = ST_RT0 + RT_N;
  localparam int ST_MUL  = ST_DIFF + 1;
  localparam int ST_TE   = ST_MUL + 1;
  localparam int ST_MAG  = ST_TE + 1;
  localparam int ST_QD0  = ST_MAG + 1;
  localparam int ST_V    = ST_QD0 + QD_N;
  localparam int ST_K    = ST_V + 1;
  localparam int ST_LN   = ST_K + 1;
  localparam int ST_TM0  = ST_LN + 1;
  localparam int ST_P1   = ST_TM0 + 2 * TM_N;
  localparam int ST_P2   = ST_P1 + 1;
  localparam int ST_P3   = ST_P2 + 1;
  localparam int ST_X    = ST_P3 + 1;
  localparam int ST_C    = ST_X + 1;
  localparam int ST_RD0  = ST_C + 1;
  localparam int ST_OUT  = ST_RD0 + RD_N;
  localparam int NS      = ST_OUT + 1;
  localparam int SH_PAD  = 67;
  localparam int N_W     = 93;
  localparam int W_W     = N_W + SH_PAD;

  // configuration registers
  logic [1:0]         wave_mode;
  logic [30:0]        peak_pressure;
  logic [31:0]        decay_time;
  logic [23:0]        slowness;
  logic signed [31:0] source_x;
  logic signed [31:0] source_y;
  logic signed [31:0] source_z;
  logic signed [31:0] front_offset;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode     <= swip_pkg::RST_WAVE_MODE;
      peak_pressure <= swip_pkg::RST_PEAK;
      decay_time    <= swip_pkg::RST_DECAY_TIME;
      slowness      <= swip_pkg::RST_SLOWNESS;
      source_x      <= '0;
      source_y      <= '0;
      source_z      <= '0;
      front_offset  <= swip_pkg::RST_FRONT_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swip_pkg::REG_WAVE_MODE:     wave_mode     <= cfg_data[1:0];
        swip_pkg::REG_PEAK_PRESSURE: peak_pressure <= cfg_data[30:0];
        swip_pkg::REG_DECAY_TIME:    decay_time    <= cfg_data;
        swip_pkg::REG_SLOWNESS:      slowness      <= cfg_data[23:0];
        swip_pkg::REG_SOURCE_X:      source_x      <= cfg_data;
        swip_pkg::REG_SOURCE_Y:      source_y      <= cfg_data;
        swip_pkg::REG_SOURCE_Z:      source_z      <= cfg_data;
        swip_pkg::REG_FRONT_OFFSET:  front_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [31:0] tau;
  assign tau = (decay_time == 32'd0) ? 32'd1 : decay_time;

  // |a - b| of two signed coordinates
  function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? (33'd0 - d) : d;
  endfunction

  // stage handshake: a stage loads when empty or when the next one loads
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  for (genvar j = 0; j < NS - 1; j++) begin : g_en
    assign en[j] = ~vld[j] | en[j+1];
  end
  assign en[NS-1] = ~vld[NS-1] | m_tready;
  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int j = 1; j < NS; j++) begin
        if (en[j]) vld[j] <= vld[j-1];
      end
    end
  end

  // sideband and its per-stage updates
  swip_pkg::side_t sd  [NS];
  swip_pkg::side_t sdn [NS];

  logic [33:0]        rt_root [RT_N];
  logic signed [63:0] te_n;
  logic               arr_n;
  logic signed [16:0] k_n;
  logic signed [17:0] rs_n;

  always_comb begin
    sdn[0]        = '0;
    sdn[0].x      = s_tdata[31:0];
    sdn[0].y      = s_tdata[63:32];
    sdn[0].t      = s_tdata[127:96];
    sdn[0].shadow = s_tuser;
    sdn[0].last   = s_tlast;
    for (int j = 1; j < NS; j++) begin
      sdn[j] = sd[j-1];
    end
    sdn[ST_DIFF].r     = rt_root[RT_N-1];
    sdn[ST_TE].arrived = arr_n;
    sdn[ST_TE].neg     = te_n[63];
    sdn[ST_K].k        = k_n;
    sdn[ST_LN].rs      = rs_n;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NS; j++) begin
      if (en[j]) sd[j] <= sdn[j];
    end
  end

  // distance components from the charge
  logic [32:0] adx, ady, adz;
  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      adx <= abs_diff(s_tdata[31:0], source_x);
      ady <= abs_diff(s_tdata[63:32], source_y);
      adz <= abs_diff(s_tdata[95:64], source_z);
    end
  end

  // squares
  logic [65:0] sqx, sqy, sqz;
  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      sqx <= adx * adx;
      sqy <= ady * ady;
      sqz <= adz * adz;
    end
  end

  // squared radius, padded to an even width
  logic [67:0] ssum;
  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      ssum <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
    end
  end

  // square root, one result bit per stage
  logic [67:0] rt_s   [RT_N];
  logic [35:0] rt_rem [RT_N];

  for (genvar g = 0; g < RT_N; g++) begin : g_rt
    localparam int B = RT_N - 1 - g;
    logic [67:0] s_in;
    logic [33:0] root_in;
    logic [35:0] rem_in;
    logic [37:0] cat, trial, sub;
    logic        ge;
    if (g == 0) begin : g_first
      assign s_in    = ssum;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_rest
      assign s_in    = rt_s[g-1];
      assign root_in = rt_root[g-1];
      assign rem_in  = rt_rem[g-1];
    end
    assign cat   = {rem_in, s_in[2*B+1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (cat >= trial);
    assign sub   = cat - trial;
    always_ff @(posedge clk) begin
      if (en[ST_RT0+g]) begin
        rt_s[g]    <= s_in;
        rt_root[g] <= {root_in[32:0], ge};
        rt_rem[g]  <= ge ? sub[35:0] : cat[35:0];
      end
    end
  end

  // distance the front still has to travel, per mode
  logic signed [35:0] dff;
  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      case (wave_mode)
        swip_pkg::MODE_PLANE_EXP:
          dff <= -{{4{front_offset[31]}}, front_offset}
                 - {{4{sd[ST_DIFF-1].y[31]}}, sd[ST_DIFF-1].y};
        swip_pkg::MODE_PLANE_STEP:
          dff <= {{4{sd[ST_DIFF-1].x[31]}}, sd[ST_DIFF-1].x}
                 - {{4{front_offset[31]}}, front_offset};
        swip_pkg::MODE_SPHERE:
          dff <= {{4{front_offset[31]}}, front_offset}
                 - $signed({2'b00, rt_root[RT_N-1]});
        default: dff <= '0;
      endcase
    end
  end

  // travel delay in q16.16 ns
  logic signed [60:0] mprod;
  always_ff @(posedge clk) begin
    if (en[ST_MUL]) mprod <= dff * $signed({1'b0, slowness});
  end

  // delayed time and arrival
  logic signed [63:0] te;
  assign te_n  = $signed({16'h0000, sd[ST_MUL].t, 16'h0000}) + {{3{mprod[60]}}, mprod};
  assign arr_n = (te_n > swip_pkg::TOL_Q16) && (wave_mode != swip_pkg::MODE_UNUSED);

  always_ff @(posedge clk) begin
    if (en[ST_TE]) te <= te_n;
  end

  // magnitude and tau divider setup
  logic [63:0] mag_n;
  logic [30:0] mg_low;
  logic [31:0] mg_rem;
  logic        mg_ovf;
  assign mag_n = sd[ST_TE].neg ? (64'd0 - te) : te;

  always_ff @(posedge clk) begin
    if (en[ST_MAG]) begin
      mg_ovf <= (mag_n[63:31] >= {1'b0, tau});
      mg_rem <= mag_n[62:31];
      mg_low <= mag_n[30:0];
    end
  end

  // |te| / tau, one quotient bit per stage
  logic [30:0] qd_low  [QD_N];
  logic [31:0] qd_rem  [QD_N];
  logic [30:0] qd_quot [QD_N];
  logic        qd_ovf  [QD_N];

  for (genvar g = 0; g < QD_N; g++) begin : g_qd
    localparam int BI = QD_N - 1 - g;
    logic [30:0] low_in, quot_in;
    logic [31:0] rem_in;
    logic        ovf_in;
    logic [32:0] cat, sub;
    logic        ge;
    if (g == 0) begin : g_first
      assign low_in  = mg_low;
      assign rem_in  = mg_rem;
      assign quot_in = '0;
      assign ovf_in  = mg_ovf;
    end else begin : g_rest
      assign low_in  = qd_low[g-1];
      assign rem_in  = qd_rem[g-1];
      assign quot_in = qd_quot[g-1];
      assign ovf_in  = qd_ovf[g-1];
    end
    assign cat = {rem_in, low_in[BI]};
    assign ge  = (cat >= {1'b0, tau});
    assign sub = cat - {1'b0, tau};
    always_ff @(posedge clk) begin
      if (en[ST_QD0+g]) begin
        qd_low[g]  <= low_in;
        qd_rem[g]  <= ge ? sub[31:0] : cat[31:0];
        qd_quot[g] <= {quot_in[29:0], ge};
        qd_ovf[g]  <= ovf_in;
      end
    end
  end

  // clamp and scale to a base-two exponent
  logic [30:0] qv;
  logic [61:0] vprod;
  assign qv = (qd_ovf[QD_N-1] || (qd_quot[QD_N-1] > swip_pkg::ONE_Q30))
              ? swip_pkg::ONE_Q30 : qd_quot[QD_N-1];

  always_ff @(posedge clk) begin
    if (en[ST_V]) vprod <= qv * swip_pkg::LOG2E_Q30;
  end

  // integer and fraction of the exponent
  logic [30:0] vv;
  logic [31:0] vs;
  logic [15:0] f_n, kf_f;
  assign vv = vprod[60:30];
  assign vs = {1'b0, vv} + 32'h0000FFFF;

  always_comb begin
    if (sd[ST_V].neg) begin
      k_n = $signed({2'b00, vv[30:16]});
      f_n = vv[15:0];
    end else begin
      k_n = -$signed({1'b0, vs[31:16]});
      f_n = 16'h0000 - vv[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_K]) kf_f <= f_n;
  end

  // series argument and final shift amount
  logic [45:0] lnp;
  logic [29:0] ln_t;
  assign lnp  = {30'd0, kf_f} * {16'd0, swip_pkg::LN2_Q30};
  assign rs_n = ((wave_mode == swip_pkg::MODE_SPHERE) ? 18'sd113 : 18'sd97)
                - {sd[ST_K].k[16], sd[ST_K].k};

  always_ff @(posedge clk) begin
    if (en[ST_LN]) ln_t <= lnp[45:16];
  end

  // 2^f by eight series terms, multiply then divide per term
  logic [29:0] ta_p   [TM_N];
  logic [29:0] ta_t   [TM_N];
  logic [30:0] ta_sum [TM_N];
  logic [30:0] tb_term[TM_N];
  logic [29:0] tb_t   [TM_N];
  logic [30:0] tb_sum [TM_N];

  for (genvar g = 0; g < TM_N; g++) begin : g_tm
    localparam logic [3:0] DIVISOR = 4'(g + 1);
    logic [30:0] term_in, sum_in;
    logic [29:0] t_in;
    logic [60:0] prod;
    logic [29:0] q;
    if (g == 0) begin : g_first
      assign term_in = swip_pkg::ONE_Q30;
      assign sum_in  = swip_pkg::ONE_Q30;
      assign t_in    = ln_t;
    end else begin : g_rest
      assign term_in = tb_term[g-1];
      assign sum_in  = tb_sum[g-1];
      assign t_in    = tb_t[g-1];
    end
    assign prod = term_in * t_in;
    assign q    = swip_pkg::div_small(ta_p[g], DIVISOR);
    always_ff @(posedge clk) begin
      if (en[ST_TM0+2*g]) begin
        ta_p[g]   <= prod[59:30];
        ta_t[g]   <= t_in;
        ta_sum[g] <= sum_in;
      end
      if (en[ST_TM0+2*g+1]) begin
        tb_term[g] <= {1'b0, q};
        tb_t[g]    <= ta_t[g];
        tb_sum[g]  <= ta_sum[g] + {1'b0, q};
      end
    end
  end

  // gain: peak times mantissa, then times reference in two partial products
  logic [61:0] pm, pl, ph;
  logic [30:0] aval;
  logic [N_W-1:0] nn;
  assign aval = (wave_mode == swip_pkg::MODE_SPHERE) ? front_offset[30:0] : 31'd1;

  always_ff @(posedge clk) begin
    if (en[ST_P1]) pm <= peak_pressure * tb_sum[TM_N-1];
    if (en[ST_P2]) begin
      pl <= pm[30:0] * aval;
      ph <= pm[61:31] * aval;
    end
    if (en[ST_P3]) nn <= {31'd0, pl} + {ph, 31'd0};
  end

  // scale by 2^(k - base), saturating far above range
  logic [W_W-1:0] wsh;
  logic [65:0]    x_n, xs;
  logic           big_n, xbig;
  assign wsh = {nn, {SH_PAD{1'b0}}} >> sd[ST_P3].rs[7:0];

  always_comb begin
    if (sd[ST_P3].rs <= 18'sd0) begin
      big_n = |nn;
      x_n   = '0;
    end else if (sd[ST_P3].rs > 18'(W_W)) begin
      big_n = 1'b0;
      x_n   = '0;
    end else begin
      big_n = |wsh[W_W-1:66];
      x_n   = wsh[65:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_X]) begin
      xs   <= x_n;
      xbig <= big_n;
    end
  end

  // radius divider setup and overflow check
  logic [33:0] dd;
  logic [33:0] cd_d, cd_rem;
  logic [30:0] cd_low;
  logic        cd_ovf;
  assign dd = (wave_mode == swip_pkg::MODE_SPHERE) ? sd[ST_X].r : 34'd1;

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      cd_ovf <= xbig || (xs >= {1'b0, dd, 31'd0});
      cd_rem <= xs[64:31];
      cd_low <= xs[30:0];
      cd_d   <= dd;
    end
  end

  // scaled gain / radius, one quotient bit per stage
  logic [33:0] rd_d    [RD_N];
  logic [33:0] rd_rem  [RD_N];
  logic [30:0] rd_low  [RD_N];
  logic [30:0] rd_quot [RD_N];
  logic        rd_ovf  [RD_N];

  for (genvar g = 0; g < RD_N; g++) begin : g_rd
    localparam int BI = RD_N - 1 - g;
    logic [33:0] d_in, rem_in;
    logic [30:0] low_in, quot_in;
    logic        ovf_in;
    logic [34:0] cat, sub;
    logic        ge;
    if (g == 0) begin : g_first
      assign d_in    = cd_d;
      assign rem_in  = cd_rem;
      assign low_in  = cd_low;
      assign quot_in = '0;
      assign ovf_in  = cd_ovf;
    end else begin : g_rest
      assign d_in    = rd_d[g-1];
      assign rem_in  = rd_rem[g-1];
      assign low_in  = rd_low[g-1];
      assign quot_in = rd_quot[g-1];
      assign ovf_in  = rd_ovf[g-1];
    end
    assign cat = {rem_in, low_in[BI]};
    assign ge  = (cat >= {1'b0, d_in});
    assign sub = cat - {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (en[ST_RD0+g]) begin
        rd_d[g]    <= d_in;
        rd_rem[g]  <= ge ? sub[33:0] : cat[33:0];
        rd_low[g]  <= low_in;
        rd_quot[g] <= {quot_in[29:0], ge};
        rd_ovf[g]  <= ovf_in;
      end
    end
  end

  // result select per mode and special case
  logic [30:0] p_n, pout;
  always_comb begin
    p_n = '0;
    if (sd[ST_OUT-1].arrived) begin
      case (wave_mode)
        swip_pkg::MODE_PLANE_STEP: p_n = peak_pressure;
        swip_pkg::MODE_PLANE_EXP:
          p_n = rd_ovf[RD_N-1] ? swip_pkg::MAX_PRESSURE : rd_quot[RD_N-1];
        swip_pkg::MODE_SPHERE: begin
          if (sd[ST_OUT-1].shadow || (front_offset <= 32'sd0)) p_n = '0;
          else p_n = rd_ovf[RD_N-1] ? swip_pkg::MAX_PRESSURE : rd_quot[RD_N-1];
        end
        default: p_n = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) pout <= p_n;
  end

  assign m_tvalid = vld[NS-1];
  assign m_tdata  = {1'b0, pout};
  assign m_tuser  = sd[ST_OUT].arrived;
  assign m_tlast  = sd[ST_OUT].last;

`ifndef SYNTHESIS
  // input side never stalls while the output side can move
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output free");

  // a nonzero pressure only comes with an arrived front
  a_pressure_arrived: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[30:0] != 31'd0)) |-> m_tuser)
    else $error("pressure without arrival");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule
